// File: rtl/vtwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtwc_pkg: shared types and constants
// Widths of the vertex transform datapath and the record handed from the
// front end to the divider back end.
// ----------------------------------------------------------------------------
package vtwc_pkg;

   localparam int CW     = 32;  // Q16.16 coordinate width
   localparam int KW     = 16;  // Q4.12 coefficient width
   localparam int PW     = CW + KW;  // product width
   localparam int HW     = 51;  // homogeneous sum width, signed
   localparam int MW     = HW - 1;  // magnitude width
   localparam int RW     = MW + 1;  // partial remainder width
   localparam int QW     = 32;  // quotient width
   localparam int FB     = 16;  // fraction bits produced by the divider
   localparam int LANES  = 3;   // numerators x, y, z
   localparam int NSTEP  = QW;  // one quotient bit per divider stage
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 64;
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [CSR_AW-1:0] CSR_ROW_X     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_ROW_Y     = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_ROW_Z     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_ROW_T     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_THRESHOLD = 3'd4;

   localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

   // One kept vertex, ready for division.
   typedef struct packed {
      logic [LANES-1:0][MW-1:0] mag_n;
      logic [MW-1:0]            mag_d;
      logic [LANES-1:0]         neg;
      logic [LANES-1:0]         nonzero;
   } job_type;

endpackage

// File: rtl/vtwc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtwc_front: matrix multiply and w test
// Two register stages form the homogeneous sums; the second stage tests w
// against the threshold and hands kept vertices to the queue as magnitudes.
// ----------------------------------------------------------------------------
module vtwc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [3*vtwc_pkg::CW-1:0] in_data,
   input  logic [63:0]               row_x,
   input  logic [63:0]               row_y,
   input  logic [63:0]               row_z,
   input  logic [63:0]               row_t,
   input  logic [vtwc_pkg::CW-1:0]   threshold,
   output logic                      push,
   output vtwc_pkg::job_type         push_job,
   input  logic                      queue_full
);
   import vtwc_pkg::*;

   logic                        f1_valid_ff, f1_valid_in;
   logic signed [PW-1:0]        prod_ff [3][4];
   logic signed [PW-1:0]        prod_in [3][4];
   logic                        f2_valid_ff, f2_valid_in;
   logic signed [HW-1:0]        h_ff [4];
   logic signed [HW-1:0]        h_in [4];
   logic signed [HW-1:0]        thr_q;
   logic                        keep;
   logic                        advance;
   logic [63:0]                 rows [3];

   assign rows[0] = row_x;
   assign rows[1] = row_y;
   assign rows[2] = row_z;

   assign thr_q   = HW'($signed(threshold)) <<< 12;
   assign keep    = h_ff[3] > thr_q;
   assign advance = !f2_valid_ff || !keep || !queue_full;
   assign in_ready = advance;
   assign push    = f2_valid_ff && keep;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 4; k++) begin
            prod_in[i][k] = $signed(in_data[i*CW +: CW]) * $signed(rows[i][k*KW +: KW]);
         end
      end
      for (int k = 0; k < 4; k++) begin
         h_in[k] = HW'(prod_ff[0][k]) + HW'(prod_ff[1][k]) + HW'(prod_ff[2][k])
                 + (HW'($signed(row_t[k*KW +: KW])) <<< 16);
      end
      f1_valid_in = in_valid;
      f2_valid_in = f1_valid_ff;
   end

   always_comb begin
      logic signed [HW-1:0] neg_h;
      neg_h = -h_ff[3];
      push_job.mag_d = h_ff[3][HW-1] ? neg_h[MW-1:0] : h_ff[3][MW-1:0];
      for (int l = 0; l < LANES; l++) begin
         push_job.mag_n[l]   = h_ff[l][HW-1] ? MW'(-h_ff[l]) : h_ff[l][MW-1:0];
         push_job.neg[l]     = h_ff[l][HW-1] ^ h_ff[3][HW-1];
         push_job.nonzero[l] = h_ff[l] != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
      if (advance) begin
         prod_ff <= prod_in;
         h_ff    <= h_in;
      end
   end

endmodule

// File: rtl/vtwc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtwc_queue: job queue
// Small first-in first-out store between the front end and the divider.
// ----------------------------------------------------------------------------
module vtwc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vtwc_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output vtwc_pkg::job_type head
);
   import vtwc_pkg::*;

   job_type          mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == (QAW+1)'(QDEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QAW'(do_push);
      rd_ptr_in = rd_ptr_ff + QAW'(do_pop);
      count_in  = count_ff + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/vtwc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtwc_back: pipelined divider
// Restoring division, one quotient bit per stage for three numerators over a
// shared w, followed by saturation into the output register.
// ----------------------------------------------------------------------------
module vtwc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_empty,
   input  vtwc_pkg::job_type         head,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [3*vtwc_pkg::QW-1:0] out_data
);
   import vtwc_pkg::*;

   logic                 valid_ff [NSTEP+1];
   logic [RW-1:0]        rem_ff   [NSTEP+1][LANES];
   logic [RW-1:0]        rem_in   [NSTEP+1][LANES];
   logic [QW-1:0]        quo_ff   [NSTEP+1][LANES];
   logic [QW-1:0]        quo_in   [NSTEP+1][LANES];
   logic [FB-1:0]        low_ff   [NSTEP+1][LANES];
   logic [FB-1:0]        low_in   [NSTEP+1][LANES];
   logic [MW-1:0]        den_ff   [NSTEP+1];
   logic [LANES-1:0]     neg_ff   [NSTEP+1];
   logic [LANES-1:0]     ovf_ff   [NSTEP+1];
   logic [LANES-1:0]     ovf_in;
   logic                 out_valid_ff;
   logic [3*QW-1:0]      out_data_ff, out_data_in;
   logic                 advance;

   assign advance   = !out_valid_ff || out_ready;
   assign pop       = advance && !queue_empty;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      logic [RW-1:0] t;
      // Entry stage: overflow test and the initial partial remainder. The
      // quotient fits only when the integer part of n / w is below 2^16.
      for (int l = 0; l < LANES; l++) begin
         ovf_in[l]    = head.nonzero[l] && ((head.mag_n[l] >> FB) >= head.mag_d);
         rem_in[0][l] = RW'(head.mag_n[l] >> FB);
         quo_in[0][l] = '0;
         low_in[0][l] = head.mag_n[l][FB-1:0];
      end
      for (int s = 1; s <= NSTEP; s++) begin
         for (int l = 0; l < LANES; l++) begin
            t = {rem_ff[s-1][l][RW-2:0], low_ff[s-1][l][FB-1]};
            if (t >= RW'(den_ff[s-1])) begin
               rem_in[s][l] = t - RW'(den_ff[s-1]);
               quo_in[s][l] = {quo_ff[s-1][l][QW-2:0], 1'b1};
            end else begin
               rem_in[s][l] = t;
               quo_in[s][l] = {quo_ff[s-1][l][QW-2:0], 1'b0};
            end
            low_in[s][l] = {low_ff[s-1][l][FB-2:0], 1'b0};
         end
      end
      // Saturate and apply the sign.
      for (int l = 0; l < LANES; l++) begin
         if (ovf_ff[NSTEP][l]) begin
            out_data_in[l*QW +: QW] = neg_ff[NSTEP][l] ? SAT_NEG : SAT_POS;
         end else if (neg_ff[NSTEP][l]) begin
            out_data_in[l*QW +: QW] = quo_ff[NSTEP][l][QW-1] ? SAT_NEG : -quo_ff[NSTEP][l];
         end else begin
            out_data_in[l*QW +: QW] = quo_ff[NSTEP][l][QW-1] ? SAT_POS : quo_ff[NSTEP][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NSTEP; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= !queue_empty;
         for (int s = 1; s <= NSTEP; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[NSTEP];
      end
      if (advance) begin
         rem_ff      <= rem_in;
         quo_ff      <= quo_in;
         low_ff      <= low_in;
         // A zero w divides by one instead, so that a zero numerator gives zero;
         // a nonzero numerator over zero w is already marked as overflow.
         den_ff[0]   <= (head.mag_d == '0) ? MW'(1) : head.mag_d;
         neg_ff[0]   <= head.neg;
         ovf_ff[0]   <= ovf_in;
         for (int s = 1; s <= NSTEP; s++) begin
            den_ff[s] <= den_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
         out_data_ff <= out_data_in;
      end
   end

endmodule

// File: rtl/vertex_transform_w_clip_top.sv
`timescale 1ns / 1ps
// An accepted req passes the front stages, the queue, the divider stages and the output register.
// Throughput: one vertex per cycle unless rsp_tready stalls the divider pipeline.
// Points whose w does not exceed the threshold are dropped and give no rsp transaction.
// Reset is synchronous and active high; it clears all valid state and loads the identity
// matrix with a zero w threshold.
// ----------------------------------------------------------------------------
// vertex_transform_w_clip_top: homogeneous vertex transform with w clipping
// Multiplies (x, y, z, 1) by a configured 4x4 fixed-point matrix and emits the
// point divided by w when w is above the threshold.
// ----------------------------------------------------------------------------
module vertex_transform_w_clip_top (
   input  logic                          clock,
   input  logic                          reset,
   // Input vertex stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [3*vtwc_pkg::CW-1:0]     req_tdata,   // vx, vy, vz from bit 0
   // Projected point stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [3*vtwc_pkg::QW-1:0]     rsp_tdata,   // ox, oy, oz from bit 0
   // Register write port.
   input  logic                          csr_we,
   input  logic [vtwc_pkg::CSR_AW-1:0]   csr_index,
   input  logic [vtwc_pkg::CSR_DW-1:0]   csr_wdata
);
   import vtwc_pkg::*;

   // Matrix rows: each holds four Q4.12 lanes feeding out x, y, z and w.
   logic [63:0]    row_x_ff, row_y_ff, row_z_ff, row_t_ff;
   logic [CW-1:0]  threshold_ff;

   logic           push;
   job_type        push_job;
   logic           queue_full;
   logic           queue_empty;
   logic           pop;
   job_type        head;

   // Registers must only be written while the block is idle, so no shadowing is needed; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff     <= 64'h0000_0000_0000_1000;
         row_y_ff     <= 64'h0000_0000_1000_0000;
         row_z_ff     <= 64'h0000_1000_0000_0000;
         row_t_ff     <= 64'h1000_0000_0000_0000;
         threshold_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_X:     row_x_ff     <= csr_wdata;
            CSR_ROW_Y:     row_y_ff     <= csr_wdata;
            CSR_ROW_Z:     row_z_ff     <= csr_wdata;
            CSR_ROW_T:     row_t_ff     <= csr_wdata;
            CSR_THRESHOLD: threshold_ff <= csr_wdata[CW-1:0];
            default:       ;
         endcase
      end
   end

   // The front end forms the sums and tests w; it stalls only when the queue is full.
   vtwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .row_x      (row_x_ff),
      .row_y      (row_y_ff),
      .row_z      (row_z_ff),
      .row_t      (row_t_ff),
      .threshold  (threshold_ff),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   // The queue lets the front keep accepting while the output is held.
   vtwc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (head)
   );

   // The back end divides all three numerators by w and holds the result.
   vtwc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata)
   );

endmodule
